### rtl/srs_pkg.sv
// Package for the stochastic reaction step block: beat types, commands,
// outcome codes, register indexes and sequencer states.
// No dependencies.
package srs_pkg;

   localparam int SEL_LIMIT     = 16;
   localparam int MAX_SPECIES   = 16;
   localparam int MAX_REACTIONS = 16;
   localparam int MAX_ORDER     = 3;
   localparam int CNT_W         = 5;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 64;
   localparam logic [63:0] LN2_Q64 = 64'hB17217F7D1CF79AB;
   localparam logic [63:0] ALL64   = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef enum logic [2:0] {
      CMD_LOAD_STOICH = 3'd0,
      CMD_LOAD_RATE   = 3'd1,
      CMD_SET_COUNT   = 3'd2,
      CMD_STEP        = 3'd3,
      CMD_RESTART     = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      OUT_FIRED    = 2'd0,
      OUT_ZERO_HAZ = 2'd1,
      OUT_END_TIME = 2'd2
   } outcome_type;

   typedef enum logic [1:0] {
      CSR_SPECIES   = 2'd0,
      CSR_REACTIONS = 2'd1,
      CSR_START     = 2'd2,
      CSR_END       = 2'd3
   } csr_type;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_R_INIT, ST_S_READ, ST_S_EVAL,
      ST_FF_GO, ST_FF_WAIT, ST_PROP_GO, ST_PROP_WAIT,
      ST_RATE_GO, ST_RATE_WAIT, ST_THR_GO, ST_THR_WAIT, ST_SEARCH,
      ST_NORM, ST_SQ_GO, ST_SQ_WAIT, ST_LN_GO, ST_LN_WAIT,
      ST_DIV_GO, ST_DIV_WAIT, ST_A_READ, ST_A_UPD, ST_EMIT
   } state_type;

   typedef struct packed {
      logic [2:0]        command;
      logic [3:0]        species_sel;
      logic [3:0]        reaction_sel;
      logic [1:0]        reactant_order;
      logic signed [3:0] net_change;
      logic [31:0]       rate_value;
      logic [15:0]       count_value;
      logic [31:0]       uniform_a;
      logic [31:0]       uniform_b;
   } req_type;

   typedef struct packed {
      logic [1:0]  outcome;
      logic [3:0]  reaction_fired;
      logic [63:0] delta_time;
      logic [63:0] time_now;
      logic [3:0]  species_index;
      logic [15:0] species_count;
      logic        last_of_run;
   } rsp_type;

endpackage

### rtl/stochastic_reaction_step.sv
// Direct-method stochastic simulation step. Before end time, per reaction: per
// species a stoichiometry read and check, falling-factorial and propensity
// products, then the rate product; if the total hazard is nonzero, then the
// threshold product, search, normalize, 32 squarings, log product, divide and
// a count update per species. Then one result beat per species. All products
// use one shared multiplier. One item at a time; loads are taken in idle.
// Synchronous reset; afterwards a sweep over every stoichiometry RAM entry
// clears the RAM while no item is accepted.
module stochastic_reaction_step #(
   parameter int MAX_SPECIES   = srs_pkg::MAX_SPECIES,
   parameter int MAX_REACTIONS = srs_pkg::MAX_REACTIONS,
   parameter int MAX_ORDER     = srs_pkg::MAX_ORDER
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  srs_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output srs_pkg::rsp_type                  rsp_data,
   input  logic                              csr_write,
   input  logic [srs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [srs_pkg::CSR_DATA_W-1:0]    csr_data
);

   import srs_pkg::*;

   localparam int NS    = (MAX_SPECIES > SEL_LIMIT) ? SEL_LIMIT : MAX_SPECIES;
   localparam int NR    = (MAX_REACTIONS > SEL_LIMIT) ? SEL_LIMIT : MAX_REACTIONS;
   localparam int SW    = (NS > 1) ? $clog2(NS) : 1;
   localparam int RW    = (NR > 1) ? $clog2(NR) : 1;
   localparam int AW    = SW + RW;
   localparam int DEPTH = 1 << AW;

   state_type state_ff, state_in;

   // configuration registers
   logic [4:0]  species_in_use_ff, reactions_in_use_ff;
   logic [63:0] start_time_ff, end_time_ff, sim_time_ff;

   logic [15:0] counts_ff [NS];
   logic [31:0] rate_ff   [NR];
   logic [63:0] hs_ff     [NR];

   logic [AW-1:0]    clr_ff;
   logic [CNT_W-1:0] ns_ff, nr_ff, ns_cl, nr_cl;
   logic [SW-1:0]    s_ff, es_ff;
   logic [RW-1:0]    r_ff, chosen_ff;
   logic [1:0]       kk_ff, j_ff, kk;
   logic [63:0]      ff_ff, prop_ff, acc_ff, thr_ff, z_ff, delta_ff, lval_ff;
   logic [31:0]      un_ff, ub_ff, f_ff;
   logic [4:0]       c_ff, i_ff;
   logic [1:0]       outcome_ff;

   logic        req_accept, emit_load, rsp_valid_ff;
   rsp_type     rsp_data_ff;
   logic        mul_start, mul_done, div_start, div_done;
   logic [63:0] mul_a, mul_b, div_quot;
   logic [127:0] mul_prod;
   logic        ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [5:0]  ram_wdata, ram_rd;

   logic        s_last, r_last, sq_bit;
   logic [63:0] haz, acc_sum, tnext, n_log;
   logic [64:0] acc_wide, t_wide;
   logic [15:0] n_cnt;
   logic signed [17:0] v_cnt;
   logic [15:0] v_sat;

   srs_ram #(.WIDTH(6), .DEPTH(DEPTH)) u_stoich (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_waddr), .wr_data(ram_wdata),
      .rd_addr(ram_raddr), .rd_data(ram_rd)
   );

   srs_mul u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .a(mul_a), .b(mul_b),
      .done(mul_done), .prod(mul_prod)
   );

   srs_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(lval_ff),
      .den(acc_ff), .done(div_done), .quot(div_quot)
   );

   // clamp the count registers into the table sizes
   always_comb begin
      if (species_in_use_ff == 5'd0)            ns_cl = CNT_W'(1);
      else if (species_in_use_ff > CNT_W'(NS))  ns_cl = CNT_W'(NS);
      else                                      ns_cl = species_in_use_ff;
      if (reactions_in_use_ff == 5'd0)          nr_cl = CNT_W'(1);
      else if (reactions_in_use_ff > CNT_W'(NR)) nr_cl = CNT_W'(NR);
      else                                      nr_cl = reactions_in_use_ff;
   end

   // shared datapath values
   always_comb begin
      req_accept = req_valid && !req_stall;
      s_last  = (CNT_W'(s_ff) == ns_ff - CNT_W'(1));
      r_last  = (CNT_W'(r_ff) == nr_ff - CNT_W'(1));
      n_cnt   = counts_ff[s_ff];
      kk      = (int'(ram_rd[5:4]) > MAX_ORDER) ? 2'(MAX_ORDER) : ram_rd[5:4];
      haz     = (mul_prod[127:64] != 64'd0) ? ALL64 : mul_prod[63:0];
      acc_wide = {1'b0, acc_ff} + {1'b0, haz};
      acc_sum  = acc_wide[64] ? ALL64 : acc_wide[63:0];
      sq_bit   = (mul_prod[127:125] != 3'd0);
      n_log    = {26'd0, 6'(c_ff) + 6'd1, 32'd0} - {32'd0, f_ff};
      t_wide   = {1'b0, sim_time_ff} + {9'd0, div_quot[63:8]};
      tnext    = t_wide[64] ? ALL64 : t_wide[63:0];
      v_cnt    = $signed({2'b00, n_cnt}) + 18'(signed'(ram_rd[3:0]));
      if (v_cnt < 0)                        v_sat = 16'd0;
      else if (v_cnt > 18'sd65535)          v_sat = 16'hFFFF;
      else                                  v_sat = v_cnt[15:0];
      emit_load = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_ff == AW'(DEPTH - 1)) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_accept && req_data.command == CMD_STEP) begin
               state_in = (sim_time_ff >= end_time_ff) ? ST_EMIT : ST_R_INIT;
            end
         end
         ST_R_INIT: state_in = ST_S_READ;
         ST_S_READ: state_in = ST_S_EVAL;
         ST_S_EVAL: begin
            if (ram_rd[5:4] == 2'd0 || n_cnt < 16'(kk)) begin
               state_in = s_last ? ST_RATE_GO : ST_S_READ;
            end else if (kk == 2'd1) begin
               state_in = ST_PROP_GO;
            end else begin
               state_in = ST_FF_GO;
            end
         end
         ST_FF_GO:   state_in = ST_FF_WAIT;
         ST_FF_WAIT: if (mul_done) state_in = (j_ff + 2'd1 < kk_ff) ? ST_FF_GO : ST_PROP_GO;
         ST_PROP_GO: state_in = ST_PROP_WAIT;
         ST_PROP_WAIT: if (mul_done) state_in = s_last ? ST_RATE_GO : ST_S_READ;
         ST_RATE_GO: state_in = ST_RATE_WAIT;
         ST_RATE_WAIT: begin
            if (mul_done) begin
               if (!r_last)                state_in = ST_R_INIT;
               else if (acc_sum == 64'd0)  state_in = ST_EMIT;
               else                        state_in = ST_THR_GO;
            end
         end
         ST_THR_GO:   state_in = ST_THR_WAIT;
         ST_THR_WAIT: if (mul_done) state_in = ST_SEARCH;
         ST_SEARCH: begin
            if (!(CNT_W'(chosen_ff) + CNT_W'(1) < nr_ff && !(hs_ff[chosen_ff] > thr_ff))) begin
               state_in = ST_NORM;
            end
         end
         ST_NORM:    if (un_ff[31]) state_in = ST_SQ_GO;
         ST_SQ_GO:   state_in = ST_SQ_WAIT;
         ST_SQ_WAIT: if (mul_done) state_in = (i_ff == 5'd31) ? ST_LN_GO : ST_SQ_GO;
         ST_LN_GO:   state_in = ST_LN_WAIT;
         ST_LN_WAIT: if (mul_done) state_in = ST_DIV_GO;
         ST_DIV_GO:  state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: if (div_done) state_in = ST_A_READ;
         ST_A_READ:  state_in = ST_A_UPD;
         ST_A_UPD:   state_in = s_last ? ST_EMIT : ST_A_READ;
         ST_EMIT:    if (emit_load && CNT_W'(es_ff) == ns_ff - CNT_W'(1)) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs: unit starts, operand selection, RAM ports
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      mul_start = 1'b0;
      mul_a     = 64'd0;
      mul_b     = 64'd0;
      div_start = (state_ff == ST_DIV_GO);
      ram_we    = 1'b0;
      ram_waddr = clr_ff;
      ram_wdata = 6'd0;
      ram_raddr = {s_ff, r_ff};
      unique case (state_ff)
         ST_CLEAR: ram_we = 1'b1;
         ST_IDLE: begin
            ram_waddr = {req_data.species_sel[SW-1:0], req_data.reaction_sel[RW-1:0]};
            ram_wdata = {req_data.reactant_order, req_data.net_change};
            ram_we    = req_accept && req_data.command == CMD_LOAD_STOICH
                        && {1'b0, req_data.species_sel} < CNT_W'(NS)
                        && {1'b0, req_data.reaction_sel} < CNT_W'(NR);
         end
         ST_FF_GO: begin
            mul_start = 1'b1;
            mul_a     = ff_ff;
            mul_b     = 64'(n_cnt) - 64'(j_ff);
         end
         ST_PROP_GO: begin
            mul_start = 1'b1;
            mul_a     = prop_ff;
            mul_b     = ff_ff;
         end
         ST_RATE_GO: begin
            mul_start = 1'b1;
            mul_a     = prop_ff;
            mul_b     = 64'(rate_ff[r_ff]);
         end
         ST_THR_GO: begin
            mul_start = 1'b1;
            mul_a     = 64'(ub_ff);
            mul_b     = acc_ff;
         end
         ST_SQ_GO: begin
            mul_start = 1'b1;
            mul_a     = z_ff;
            mul_b     = z_ff;
         end
         ST_LN_GO: begin
            mul_start = 1'b1;
            mul_a     = n_log;
            mul_b     = LN2_Q64;
         end
         ST_A_READ: ram_raddr = {s_ff, chosen_ff};
         default: ;
      endcase
   end

   // control state, architectural state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff            <= ST_CLEAR;
         clr_ff              <= '0;
         species_in_use_ff   <= 5'd1;
         reactions_in_use_ff <= 5'd1;
         start_time_ff       <= 64'd0;
         end_time_ff         <= 64'd0;
         sim_time_ff         <= 64'd0;
         rsp_valid_ff        <= 1'b0;
         for (int k = 0; k < NS; k++) counts_ff[k] <= 16'd0;
         for (int k = 0; k < NR; k++) rate_ff[k] <= 32'd0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + AW'(1);
         if (csr_write) begin
            unique case (csr_index)
               CSR_SPECIES:   species_in_use_ff   <= csr_data[4:0];
               CSR_REACTIONS: reactions_in_use_ff <= csr_data[4:0];
               CSR_START:     start_time_ff       <= csr_data;
               default:       end_time_ff         <= csr_data;
            endcase
         end
         if (state_ff == ST_IDLE && req_accept) begin
            unique case (req_data.command)
               CMD_LOAD_RATE: begin
                  if ({1'b0, req_data.reaction_sel} < CNT_W'(NR)) begin
                     rate_ff[req_data.reaction_sel[RW-1:0]] <= req_data.rate_value;
                  end
               end
               CMD_SET_COUNT: begin
                  if ({1'b0, req_data.species_sel} < CNT_W'(NS)) begin
                     counts_ff[req_data.species_sel[SW-1:0]] <= req_data.count_value;
                  end
               end
               CMD_RESTART: sim_time_ff <= start_time_ff;
               default: ;
            endcase
         end
         if (state_ff == ST_DIV_WAIT && div_done) sim_time_ff <= tnext;
         if (state_ff == ST_A_UPD) counts_ff[s_ff] <= v_sat;
         // hold the result beat until taken, drop it once taken
         if (emit_load)       rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // working registers of the step
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            ns_ff      <= ns_cl;
            nr_ff      <= nr_cl;
            ub_ff      <= req_data.uniform_b;
            un_ff      <= (req_data.uniform_a == 32'd0) ? 32'd1 : req_data.uniform_a;
            c_ff       <= 5'd0;
            r_ff       <= '0;
            acc_ff     <= 64'd0;
            chosen_ff  <= '0;
            delta_ff   <= 64'd0;
            es_ff      <= '0;
            outcome_ff <= (sim_time_ff >= end_time_ff) ? OUT_END_TIME : OUT_FIRED;
         end
         ST_R_INIT: begin
            prop_ff <= 64'd1;
            s_ff    <= '0;
         end
         ST_S_EVAL: begin
            kk_ff <= kk;
            j_ff  <= 2'd1;
            ff_ff <= 64'(n_cnt);
            if (ram_rd[5:4] != 2'd0 && n_cnt < 16'(kk)) prop_ff <= 64'd0;
            if ((ram_rd[5:4] == 2'd0 || n_cnt < 16'(kk)) && !s_last) s_ff <= s_ff + SW'(1);
         end
         ST_FF_WAIT: begin
            if (mul_done) begin
               ff_ff <= mul_prod[63:0];
               j_ff  <= j_ff + 2'd1;
            end
         end
         ST_PROP_WAIT: begin
            if (mul_done) begin
               prop_ff <= haz;
               if (!s_last) s_ff <= s_ff + SW'(1);
            end
         end
         ST_RATE_WAIT: begin
            if (mul_done) begin
               acc_ff       <= acc_sum;
               hs_ff[r_ff]  <= acc_sum;
               if (!r_last) r_ff <= r_ff + RW'(1);
               if (r_last && acc_sum == 64'd0) outcome_ff <= OUT_ZERO_HAZ;
            end
         end
         ST_THR_WAIT: if (mul_done) thr_ff <= mul_prod[95:32];
         ST_SEARCH: begin
            if (CNT_W'(chosen_ff) + CNT_W'(1) < nr_ff && !(hs_ff[chosen_ff] > thr_ff)) begin
               chosen_ff <= chosen_ff + RW'(1);
            end
         end
         ST_NORM: begin
            // bring the leading one to the top of the word
            if (un_ff[31]) begin
               z_ff <= {1'b0, un_ff, 31'd0};
               f_ff <= 32'd0;
               i_ff <= 5'd0;
            end else begin
               un_ff <= {un_ff[30:0], 1'b0};
               c_ff  <= c_ff + 5'd1;
            end
         end
         ST_SQ_WAIT: begin
            if (mul_done) begin
               f_ff <= {f_ff[30:0], sq_bit};
               z_ff <= sq_bit ? mul_prod[126:63] : mul_prod[125:62];
               i_ff <= i_ff + 5'd1;
            end
         end
         ST_LN_WAIT: if (mul_done) lval_ff <= mul_prod[103:40];
         ST_DIV_WAIT: begin
            if (div_done) begin
               delta_ff <= {8'd0, div_quot[63:8]};
               s_ff     <= '0;
            end
         end
         ST_A_UPD: if (!s_last) s_ff <= s_ff + SW'(1);
         ST_EMIT: begin
            if (emit_load) begin
               rsp_data_ff.outcome        <= outcome_ff;
               rsp_data_ff.reaction_fired <= 4'(chosen_ff);
               rsp_data_ff.delta_time     <= delta_ff;
               rsp_data_ff.time_now       <= sim_time_ff;
               rsp_data_ff.species_index  <= 4'(es_ff);
               rsp_data_ff.species_count  <= counts_ff[es_ff];
               rsp_data_ff.last_of_run    <= (CNT_W'(es_ff) == ns_ff - CNT_W'(1));
               es_ff                      <= es_ff + SW'(1);
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a result that did not fire carries no waiting time and no reaction
   a_no_fire_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.outcome != OUT_FIRED |->
         rsp_data.delta_time == 64'd0 && rsp_data.reaction_fired == 4'd0)
      else $error("non-fired result carries a delta or reaction");

   // the divider finishes only while the sequencer waits for it
   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV_WAIT)
      else $error("divider finished outside its wait state");

   // a product arrives only while the sequencer waits for one
   a_mul_owner: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == ST_FF_WAIT || state_ff == ST_PROP_WAIT ||
                    state_ff == ST_RATE_WAIT || state_ff == ST_THR_WAIT ||
                    state_ff == ST_SQ_WAIT || state_ff == ST_LN_WAIT))
      else $error("multiplier finished outside a wait state");

   // a step is taken only once the clearing sweep is over
   a_clear_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |=> state_ff == ST_CLEAR || state_ff == ST_IDLE)
      else $error("sequencer left the clearing sweep early");

endmodule

### rtl/srs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module srs_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write one entry, read one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/srs_mul.sv
// Shared 64x64 multiplier built from one 32x32 multiplier over four passes.
// Depends on nothing; the product is held until the next start.
module srs_mul (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [63:0]  a,
   input  logic [63:0]  b,
   output logic         done,
   output logic [127:0] prod
);

   logic [63:0]  a_ff, b_ff;
   logic [63:0]  pp_ff, pp_in;
   logic [127:0] acc_ff;
   logic [2:0]   cnt_ff;
   logic         busy_ff, done_ff;
   logic [6:0]   shift;

   // pick the partial product for this pass
   always_comb begin
      unique case (cnt_ff[1:0])
         2'd0:    pp_in = a_ff[31:0]  * b_ff[31:0];
         2'd1:    pp_in = a_ff[31:0]  * b_ff[63:32];
         2'd2:    pp_in = a_ff[63:32] * b_ff[31:0];
         default: pp_in = a_ff[63:32] * b_ff[63:32];
      endcase
   end

   // weight of the partial product registered on the previous pass
   always_comb begin
      unique case (cnt_ff)
         3'd2, 3'd3: shift = 7'd32;
         3'd4:       shift = 7'd64;
         default:    shift = 7'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 3'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 3'd0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 3'd1;
            if (cnt_ff == 3'd4) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // operand capture and accumulation
   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= a;
         b_ff   <= b;
         acc_ff <= '0;
      end else if (busy_ff) begin
         if (cnt_ff != 3'd4) begin
            pp_ff <= pp_in;
         end
         if (cnt_ff != 3'd0) begin
            acc_ff <= acc_ff + (128'(pp_ff) << shift);
         end
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

### rtl/srs_div.sv
// Restoring 64-by-64 unsigned divider, one quotient bit per cycle.
// Depends on nothing; the divisor must be nonzero.
module srs_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] num,
   input  logic [63:0] den,
   output logic        done,
   output logic [63:0] quot
);

   logic [63:0] rem_ff, quot_ff, den_ff;
   logic [64:0] trial;
   logic [5:0]  cnt_ff;
   logic        busy_ff, done_ff;

   assign trial = {rem_ff, quot_ff[63]} - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 6'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 6'd0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // shift in one dividend bit, subtract when it fits
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= '0;
         quot_ff <= num;
         den_ff  <= den;
      end else if (busy_ff) begin
         if (!trial[64]) begin
            rem_ff  <= trial[63:0];
            quot_ff <= {quot_ff[62:0], 1'b1};
         end else begin
            rem_ff  <= {rem_ff[62:0], quot_ff[63]};
            quot_ff <= {quot_ff[62:0], 1'b0};
         end
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

### bench/tb.sv
// Testbench for stochastic_reaction_step: drives load, step and restart beats,
// predicts every species-count beat with a local model of the SSA step.
// Depends on srs_pkg and the stochastic_reaction_step RTL.
module tb;
   import srs_pkg::*;

   localparam int CYCLE_LIMIT  = 5000000;
   localparam int ITEM_TARGET  = 370;
   localparam int SETTLE       = 40;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   req_type          req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   rsp_type          rsp_data;
   logic             csr_write;
   logic [1:0]       csr_index;
   logic [63:0]      csr_data;

   // local copy of the block state
   logic [1:0]        order_mem [16][16];
   logic signed [3:0] change_mem [16][16];
   logic [31:0]       rate_mem [16];
   logic [15:0]       count_mem [16];
   logic [63:0]       clock_now;
   logic [4:0]        species_reg;
   logic [4:0]        reactions_reg;
   logic [63:0]       start_reg;
   logic [63:0]       end_reg;

   rsp_type          count_beats_due[$];
   int               items_sent;
   int               cycles;
   int               errors;
   int               stall_hold;
   bit               calm;

   stochastic_reaction_step u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // saturating arithmetic helpers
   function automatic logic [63:0] mul_sat(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = {64'b0, a} * {64'b0, b};
      return (p[127:64] != 0) ? ALL64 : p[63:0];
   endfunction

   function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? ALL64 : s[63:0];
   endfunction

   function automatic int clamp_reg(logic [4:0] v);
      if (v < 1) return 1;
      if (v > 16) return 16;
      return int'(v);
   endfunction

   // -ln(u / 2^32) in UQ8.56, log2 found bit by bit by squaring
   function automatic logic [63:0] neg_ln_q56(logic [31:0] u);
      int p;
      logic [63:0] z, f, n;
      logic [127:0] sq;
      if (u == 0) u = 1;
      p = 31;
      while (!u[p]) p--;
      z = {32'b0, u} << (62 - p);
      f = 0;
      for (int i = 0; i < 32; i++) begin
         sq = {64'b0, z} * {64'b0, z};
         f = f << 1;
         if (sq[127:64] >= 64'h2000_0000_0000_0000) begin
            f[0] = 1'b1;
            z = sq[126:63];
         end else begin
            z = sq[125:62];
         end
      end
      n = (64'(32 - p) << 32) - f;
      sq = {64'b0, n} * {64'b0, LN2_Q64};
      return sq[103:40];
   endfunction

   // one SSA step: hazards, choice, time advance, count update, beats
   task automatic predict_step(req_type r);
      int ns, nr, chosen, k, v;
      outcome_type oc;
      logic [63:0] acc, total, thr, delta, prop, ff, n;
      logic [63:0] sums [16];
      logic [127:0] wide;
      rsp_type b;
      ns = clamp_reg(species_reg);
      nr = clamp_reg(reactions_reg);
      chosen = 0;
      delta = 0;
      if (clock_now >= end_reg) begin
         oc = OUT_END_TIME;
      end else begin
         acc = 0;
         for (int ri = 0; ri < nr; ri++) begin
            prop = 1;
            for (int si = 0; si < ns; si++) begin
               k = order_mem[si][ri];
               if (k != 0) begin
                  n = count_mem[si];
                  ff = 1;
                  if (n < k) ff = 0;
                  else for (int j = 0; j < k; j++) ff = ff * (n - j);
                  prop = mul_sat(prop, ff);
               end
            end
            acc = add_sat(acc, mul_sat(prop, {32'b0, rate_mem[ri]}));
            sums[ri] = acc;
         end
         total = sums[nr - 1];
         if (total == 0) begin
            oc = OUT_ZERO_HAZ;
         end else begin
            oc = OUT_FIRED;
            wide = {96'b0, r.uniform_b} * {64'b0, total};
            thr = wide[95:32];
            while (chosen + 1 < nr && !(sums[chosen] > thr)) chosen++;
            delta = (neg_ln_q56(r.uniform_a) / total) >> 8;
            clock_now = add_sat(clock_now, delta);
            for (int si = 0; si < ns; si++) begin
               v = int'(count_mem[si]) + int'(change_mem[si][chosen]);
               if (v < 0) v = 0;
               if (v > 65535) v = 65535;
               count_mem[si] = v[15:0];
            end
         end
      end
      for (int si = 0; si < ns; si++) begin
         b.outcome        = oc;
         b.reaction_fired = (oc == OUT_FIRED) ? chosen[3:0] : 4'd0;
         b.delta_time     = (oc == OUT_FIRED) ? delta : 64'd0;
         b.time_now       = clock_now;
         b.species_index  = si[3:0];
         b.species_count  = count_mem[si];
         b.last_of_run    = (si + 1 == ns);
         count_beats_due = {count_beats_due, b};
      end
   endtask

   task automatic apply_item(req_type r);
      case (r.command)
         CMD_LOAD_STOICH: begin
            order_mem[r.species_sel][r.reaction_sel]  = r.reactant_order;
            change_mem[r.species_sel][r.reaction_sel] = r.net_change;
         end
         CMD_LOAD_RATE: rate_mem[r.reaction_sel] = r.rate_value;
         CMD_SET_COUNT: count_mem[r.species_sel] = r.count_value;
         CMD_STEP:      predict_step(r);
         CMD_RESTART:   clock_now = start_reg;
         default: ;
      endcase
   endtask

   // send one beat after a random gap, or none when calm; keep valid high when the gap is zero
   task automatic send_item(req_type r);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      apply_item(r);
      items_sent++;
   endtask

   // hold off until every due beat has come and the block has settled
   task automatic drain();
      req_valid <= 1'b0;
      while (count_beats_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(csr_type idx, logic [63:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_SPECIES:   species_reg   = value[4:0];
         CSR_REACTIONS: reactions_reg = value[4:0];
         CSR_START:     start_reg     = value;
         default:       end_reg       = value;
      endcase
   endtask

   // beat builders; unused fields carry random noise
   function automatic req_type noise_req(logic [2:0] cmd);
      req_type r;
      logic [191:0] noise;
      noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      r = noise[$bits(req_type)-1:0];
      r.command = cmd;
      return r;
   endfunction

   function automatic req_type stoich_req(int s, int rc, int ord, int chg);
      req_type r;
      r = noise_req(CMD_LOAD_STOICH);
      r.species_sel    = s[3:0];
      r.reaction_sel   = rc[3:0];
      r.reactant_order = ord[1:0];
      r.net_change     = chg[3:0];
      return r;
   endfunction

   function automatic req_type rate_req(int rc, logic [31:0] v);
      req_type r;
      r = noise_req(CMD_LOAD_RATE);
      r.reaction_sel = rc[3:0];
      r.rate_value   = v;
      return r;
   endfunction

   function automatic req_type count_req(int s, logic [15:0] v);
      req_type r;
      r = noise_req(CMD_SET_COUNT);
      r.species_sel = s[3:0];
      r.count_value = v;
      return r;
   endfunction

   function automatic req_type step_req(logic [31:0] a, logic [31:0] b);
      req_type r;
      r = noise_req(CMD_STEP);
      r.uniform_a = a;
      r.uniform_b = b;
      return r;
   endfunction

   // compare one field and report a mismatch
   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         errors++;
      end
   endtask

   // check every accepted result beat against the oldest due beat
   always @(posedge clock) begin
      rsp_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (count_beats_due.size() == 0) begin
            $display("%0t: result beat with nothing due, actual %h", $time, rsp_data);
            errors++;
         end else begin
            due = count_beats_due.pop_front();
            check_field("outcome", 64'(due.outcome), 64'(rsp_data.outcome));
            check_field("reaction_fired", 64'(due.reaction_fired),
                        64'(rsp_data.reaction_fired));
            check_field("delta_time", due.delta_time, rsp_data.delta_time);
            check_field("time_now", due.time_now, rsp_data.time_now);
            check_field("species_index", 64'(due.species_index),
                        64'(rsp_data.species_index));
            check_field("species_count", 64'(due.species_count),
                        64'(rsp_data.species_count));
            check_field("last_of_run", 64'(due.last_of_run), 64'(rsp_data.last_of_run));
         end
      end
   end

   // result-side stall: a random hold after each accepted beat
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_hold = 0;
      end else if (stall_hold > 0) begin
         stall_hold--;
         rsp_stall <= (stall_hold > 0);
      end else if (rsp_valid && !rsp_stall) begin
         stall_hold = calm ? 0 : $urandom_range(0, 18);
         rsp_stall <= (stall_hold > 0);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // small two-species model: A -> B and B -> A, uniform extremes
   task automatic test_directed();
      write_reg(CSR_SPECIES, 64'd2);
      write_reg(CSR_REACTIONS, 64'd2);
      write_reg(CSR_END, ALL64);
      send_item(stoich_req(0, 0, 1, -1));
      send_item(stoich_req(1, 0, 0, 1));
      send_item(stoich_req(1, 1, 1, -1));
      send_item(stoich_req(0, 1, 0, 1));
      send_item(rate_req(0, 32'h0001_0000));
      send_item(rate_req(1, 32'hFFFF_FFFF));
      send_item(count_req(0, 16'd100));
      send_item(step_req(32'd1, 32'd0));
      send_item(step_req(32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_item(step_req(32'd0, 32'h8000_0000));
      // drive counts to the rails
      send_item(count_req(0, 16'hFFFF));
      send_item(stoich_req(0, 0, 3, 7));
      send_item(stoich_req(1, 0, 0, -8));
      send_item(step_req(32'h1234_5678, 32'd0));
      // zero total hazard
      send_item(rate_req(0, 32'd0));
      send_item(rate_req(1, 32'd0));
      send_item(step_req(32'h4000_0000, 32'd7));
      send_item(noise_req(3'd5));
      send_item(noise_req(3'd6));
      send_item(noise_req(3'd7));
      send_item(noise_req(CMD_RESTART));
      drain();
   endtask

   // end time reached, restart, and time saturation
   task automatic test_end_time();
      write_reg(CSR_START, 64'h0000_0005_0000_0000);
      write_reg(CSR_END, 64'h0000_0005_0000_0000);
      send_item(rate_req(0, 32'h0010_0000));
      send_item(count_req(0, 16'd50));
      send_item(noise_req(CMD_RESTART));
      send_item(step_req($urandom | 1, $urandom));
      drain();
      write_reg(CSR_START, 64'hFFFF_FFFF_FFFF_FF00);
      write_reg(CSR_END, ALL64);
      send_item(rate_req(0, 32'd1));
      send_item(noise_req(CMD_RESTART));
      send_item(step_req(32'd1, $urandom));
      send_item(step_req(32'd1, $urandom));
      drain();
   endtask

   // register rails: zero and oversized counts, full-size saturating model
   task automatic test_register_rails();
      write_reg(CSR_START, 64'd0);
      write_reg(CSR_SPECIES, 64'd0);
      write_reg(CSR_REACTIONS, 64'd31);
      send_item(noise_req(CMD_RESTART));
      send_item(step_req($urandom, $urandom));
      drain();
      write_reg(CSR_SPECIES, 64'd16);
      write_reg(CSR_REACTIONS, 64'd16);
      for (int s = 0; s < 16; s++) begin
         send_item(stoich_req(s, 15, 3, $urandom_range(0, 15)));
         send_item(count_req(s, 16'hFFFF));
      end
      send_item(rate_req(15, 32'hFFFF_FFFF));
      send_item(step_req($urandom, $urandom));
      send_item(step_req($urandom, $urandom));
      drain();
      write_reg(CSR_SPECIES, 64'd31);
      write_reg(CSR_REACTIONS, 64'd0);
      send_item(step_req($urandom, $urandom));
      drain();
   endtask

   // random models of random size, then random steps with some noise
   task automatic test_random_models();
      int ns, nr, steps;
      while (items_sent < ITEM_TARGET) begin
         calm = ($urandom_range(0, 4) == 0);
         ns = ($urandom_range(0, 7) == 0) ? 16 : $urandom_range(1, 4);
         nr = ($urandom_range(0, 7) == 0) ? 16 : $urandom_range(1, 4);
         write_reg(CSR_SPECIES, 64'(ns));
         write_reg(CSR_REACTIONS, 64'(nr));
         write_reg(CSR_START, {32'($urandom_range(0, 3)), $urandom});
         write_reg(CSR_END, ($urandom_range(0, 5) == 0) ?
                   {32'($urandom_range(0, 8)), $urandom} : ALL64);
         send_item(noise_req(CMD_RESTART));
         for (int ri = 0; ri < nr; ri++) begin
            for (int si = 0; si < ns; si++)
               if ($urandom_range(0, 2) == 0 || ns <= 4)
                  send_item(stoich_req(si, ri, ($urandom_range(0, 3) == 0) ?
                     $urandom_range(0, 3) : $urandom_range(0, 1), $urandom_range(0, 15)));
            send_item(rate_req(ri, $urandom >> $urandom_range(0, 31)));
         end
         for (int si = 0; si < ns; si++)
            send_item(count_req(si, ($urandom_range(0, 5) == 0) ?
               16'($urandom) : 16'($urandom_range(0, 40))));
         steps = $urandom_range(4, 12);
         for (int i = 0; i < steps; i++) begin
            case ($urandom_range(0, 9))
               0: send_item(noise_req(3'($urandom_range(5, 7))));
               1: send_item(count_req($urandom_range(0, ns - 1), 16'($urandom)));
               2: send_item(noise_req(CMD_RESTART));
               default: send_item(step_req($urandom, $urandom));
            endcase
         end
         drain();
      end
      calm = 1'b0;
   endtask

   initial begin
      reset      <= 1'b1;
      req_valid  <= 1'b0;
      req_data   <= '0;
      csr_write  <= 1'b0;
      csr_index  <= '0;
      csr_data   <= '0;
      items_sent = 0;
      cycles     = 0;
      errors     = 0;
      calm       = 1'b0;
      for (int s = 0; s < 16; s++) begin
         for (int r = 0; r < 16; r++) begin
            order_mem[s][r]  = '0;
            change_mem[s][r] = '0;
         end
         rate_mem[s]  = '0;
         count_mem[s] = '0;
      end
      clock_now     = '0;
      species_reg   = 5'd1;
      reactions_reg = 5'd1;
      start_reg     = '0;
      end_reg       = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      // wait out the post-reset table sweep
      do @(posedge clock); while (req_stall);

      test_directed();
      test_end_time();
      test_register_rails();
      test_random_models();
      drain();

      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

### files.f
rtl/srs_pkg.sv
rtl/srs_ram.sv
rtl/srs_mul.sv
rtl/srs_div.sv
rtl/stochastic_reaction_step.sv
bench/tb.sv
